// ----- rtl/core/nlcm_pkg.sv -----
package nlcm_pkg;

  localparam int VAL_W = 32;
  localparam int CFG_W = 7;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DIV,
    S_STORE,
    S_BRD,
    S_BCHK,
    S_TOPW,
    S_INS_START,
    S_INS_NEXT,
    S_INS_CMP,
    S_POP_CHK,
    S_POP_TOP,
    S_POP_LAST,
    S_SD_NEXT,
    S_SD_L,
    S_SD_R,
    S_POP_FILL,
    S_DONE,
    S_CLR
  } nlcm_state_t;

endpackage

// ----- rtl/core/nlcm_ram.sv -----
module nlcm_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [W-1:0]                          wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [W-1:0]                          rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/core/nth_largest_column_merge.sv -----
// Channel   Ports                          Handshake
// -------   -----------------------------  ---------------------------------
// input     in_value                       taken when start && !busy
// result    out_nth_largest                valid for one cycle on out_strobe
// config    cfg_n_used                     written when cfg_we
//
// A word is taken only from idle; the next word waits until the last is
// stored. Its column is found by a bit-serial remainder of the IW-bit load
// count by N, one bit per cycle. The word that completes a grid also runs the
// heap build and N pops over the heap RAM (one read and one write per cycle),
// then clears the fill counts of all MAX_N columns. rst_n is synchronous; job
// counters clear at once and the same fill clear follows reset with busy high.
// The receiver cannot stall out_strobe.
module nth_largest_column_merge #(
  parameter int MAX_N = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [nlcm_pkg::VAL_W-1:0]  in_value,
  output logic                               out_strobe,
  output logic signed [nlcm_pkg::VAL_W-1:0]  out_nth_largest,
  input  logic                               cfg_we,
  input  logic [nlcm_pkg::CFG_W-1:0]         cfg_n_used
);

  import nlcm_pkg::*;

  localparam int FW   = $clog2(MAX_N + 1);                 // counts 0..MAX_N
  localparam int CW   = (MAX_N > 1) ? $clog2(MAX_N) : 1;   // column index
  localparam int IW   = $clog2(MAX_N * MAX_N + 1);         // load counter
  localparam int DCW  = $clog2(IW + 1);
  localparam int SD   = MAX_N * MAX_N;
  localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
  localparam int HD   = MAX_N + 1;
  localparam int HAW  = $clog2(HD);
  localparam int KW   = VAL_W + CW;                        // heap word {value, column}
  localparam int PW   = 2 * FW + 1;

  nlcm_state_t st_r, st_nxt;

  logic [CFG_W-1:0]        cfg_r;
  logic [FW-1:0]           n_eff;
  logic [IW-1:0]           items_r, items_nxt;
  logic [IW-1:0]           dsh_r, dsh_nxt;
  logic [DCW-1:0]          dcnt_r, dcnt_nxt;
  logic [FW-1:0]           rem_r, rem_nxt;
  logic [FW-1:0]           col_r, col_nxt;
  logic [FW-1:0]           i_r, i_nxt;
  logic [FW-1:0]           size_r, size_nxt;
  logic [FW-1:0]           t_r, t_nxt;
  logic [CW-1:0]           cur_r, cur_nxt;
  logic [CW-1:0]           pc_r, pc_nxt;
  logic                    build_r, build_nxt;
  logic [KW-1:0]           key_r, key_nxt;
  logic [KW-1:0]           left_r, left_nxt;
  logic signed [VAL_W-1:0] last_r, last_nxt;
  logic signed [VAL_W-1:0] value_r, value_nxt;
  logic [FW-1:0]           clr_r, clr_nxt;

  // memories
  logic                    s_we;
  logic [SAW-1:0]          s_waddr, s_raddr;
  logic [VAL_W-1:0]        s_rdata;
  logic                    h_we;
  logic [HAW-1:0]          h_waddr, h_raddr;
  logic [KW-1:0]           h_wdata, h_rdata;

  // fill counts, read ahead of use through a registered read port
  logic                    f_we;
  logic [CW-1:0]           f_waddr, f_raddr;
  logic [FW-1:0]           f_wdata, f_rdata;

  // compares and helpers
  logic [16:0]             n_raw;
  logic [FW:0]             div_sh;
  logic                    div_ge;
  logic [CW-1:0]           st_col;
  logic [FW-1:0]           st_fill;
  logic [FW-1:0]           bld_fill;
  logic [FW-1:0]           pop_fill_m1;
  logic [2*FW-1:0]         nn;
  logic                    job_done;
  logic signed [VAL_W-1:0] key_val, hr_val, left_val, ch_val;
  logic [FW:0]             two_t;
  logic                    has_child, has_right, pick_right;
  logic [KW-1:0]           ch_word;
  logic [FW-1:0]           ch_idx;
  logic                    ins_move, left_move, ch_move;

  // N clamped to 1..MAX_N
  assign n_raw = 17'(cfg_r);
  always_comb begin
    if (n_raw == 17'd0) begin
      n_eff = FW'(1);
    end else if (n_raw > 17'(MAX_N)) begin
      n_eff = FW'(MAX_N);
    end else begin
      n_eff = FW'(cfg_r);
    end
  end

  assign div_sh   = {rem_r, dsh_r[IW-1]};
  assign div_ge   = div_sh >= {1'b0, n_eff};
  assign st_col   = CW'(rem_r);
  assign st_fill  = f_rdata;
  assign bld_fill = f_rdata;
  assign pop_fill_m1 = f_rdata - FW'(1);
  assign nn       = n_eff * n_eff;
  assign job_done = (PW'(items_r) + PW'(1)) >= PW'(nn);

  assign key_val  = key_r[KW-1:CW];
  assign hr_val   = h_rdata[KW-1:CW];
  assign left_val = left_r[KW-1:CW];
  assign two_t    = {t_r, 1'b0};
  assign has_child  = two_t <= {1'b0, size_r};
  assign has_right  = two_t < {1'b0, size_r};
  assign pick_right = left_val < hr_val;
  assign ch_word  = pick_right ? h_rdata : left_r;
  assign ch_idx   = pick_right ? FW'(two_t + (FW+1)'(1)) : FW'(two_t);
  assign ch_val   = ch_word[KW-1:CW];
  assign ins_move  = hr_val < key_val;
  assign left_move = hr_val > key_val;
  assign ch_move   = ch_val > key_val;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:      if (start) st_nxt = S_DIV;
      S_DIV:       if (dcnt_r == DCW'(1)) st_nxt = S_STORE;
      S_STORE:     st_nxt = job_done ? S_BRD : S_IDLE;
      S_BRD:       st_nxt = S_BCHK;
      S_BCHK: begin
        if (col_r == n_eff) begin
          st_nxt = S_POP_CHK;
        end else if (bld_fill != '0) begin
          st_nxt = S_TOPW;
        end else begin
          st_nxt = S_BRD;
        end
      end
      S_TOPW:      st_nxt = S_INS_START;
      S_INS_START: st_nxt = S_INS_NEXT;
      S_INS_NEXT: begin
        if (t_r == FW'(1)) begin
          st_nxt = build_r ? S_BRD : S_POP_CHK;
        end else begin
          st_nxt = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (ins_move) begin
          st_nxt = S_INS_NEXT;
        end else begin
          st_nxt = build_r ? S_BRD : S_POP_CHK;
        end
      end
      S_POP_CHK:   st_nxt = (i_r == n_eff || size_r == '0) ? S_DONE : S_POP_TOP;
      S_POP_TOP:   st_nxt = S_POP_LAST;
      S_POP_LAST:  st_nxt = S_SD_NEXT;
      S_SD_NEXT:   st_nxt = has_child ? S_SD_L : S_POP_FILL;
      S_SD_L: begin
        if (has_right) begin
          st_nxt = S_SD_R;
        end else begin
          st_nxt = left_move ? S_SD_NEXT : S_POP_FILL;
        end
      end
      S_SD_R:      st_nxt = ch_move ? S_SD_NEXT : S_POP_FILL;
      S_POP_FILL:  st_nxt = (pop_fill_m1 != '0) ? S_TOPW : S_POP_CHK;
      S_DONE:      st_nxt = S_CLR;
      S_CLR:       if (clr_r == FW'(MAX_N - 1)) st_nxt = S_IDLE;
      default:     st_nxt = S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    items_nxt = items_r;
    dsh_nxt   = dsh_r;
    dcnt_nxt  = dcnt_r;
    rem_nxt   = rem_r;
    col_nxt   = col_r;
    i_nxt     = i_r;
    size_nxt  = size_r;
    t_nxt     = t_r;
    cur_nxt   = cur_r;
    pc_nxt    = pc_r;
    build_nxt = build_r;
    key_nxt   = key_r;
    left_nxt  = left_r;
    last_nxt  = last_r;
    value_nxt = value_r;
    clr_nxt   = clr_r;
    s_we      = 1'b0;
    s_waddr   = SAW'(st_col) * SAW'(MAX_N) + SAW'(st_fill);
    s_raddr   = '0;
    h_we      = 1'b0;
    h_waddr   = HAW'(t_r);
    h_wdata   = key_r;
    h_raddr   = '0;
    f_we      = 1'b0;
    f_waddr   = st_col;
    f_wdata   = st_fill + FW'(1);
    f_raddr   = pc_r;          // held through the sift so S_POP_FILL sees it
    out_strobe = 1'b0;

    case (st_r)
      S_IDLE: begin
        if (start) begin
          value_nxt = in_value;
          dsh_nxt   = items_r;
          dcnt_nxt  = DCW'(IW);
          rem_nxt   = '0;
        end
      end
      S_DIV: begin
        rem_nxt  = div_ge ? FW'(div_sh - {1'b0, n_eff}) : FW'(div_sh);
        dsh_nxt  = dsh_r << 1;
        dcnt_nxt = dcnt_r - DCW'(1);
        f_raddr  = CW'(rem_nxt);   // last pass leaves the column's fill
      end
      S_STORE: begin
        if (st_fill < FW'(MAX_N)) begin
          s_we = 1'b1;
          f_we = 1'b1;
        end
        items_nxt = items_r + IW'(1);
        col_nxt   = '0;
        i_nxt     = '0;
        size_nxt  = '0;
        last_nxt  = '0;
        build_nxt = 1'b1;
      end
      S_BRD: f_raddr = CW'(col_r);
      S_BCHK: begin
        s_raddr = SAW'(CW'(col_r)) * SAW'(MAX_N) + SAW'(bld_fill - FW'(1));
        cur_nxt = CW'(col_r);
        if (col_r == n_eff) begin
          build_nxt = 1'b0;
        end else if (bld_fill == '0) begin
          col_nxt = col_r + FW'(1);
        end
      end
      S_TOPW: key_nxt = {s_rdata, cur_r};
      S_INS_START: begin
        size_nxt = size_r + FW'(1);
        t_nxt    = size_r + FW'(1);
      end
      S_INS_NEXT: begin
        h_raddr = HAW'(t_r >> 1);
        if (t_r == FW'(1)) begin
          h_we = 1'b1;
          if (build_r) col_nxt = col_r + FW'(1);
          else         i_nxt   = i_r + FW'(1);
        end
      end
      S_INS_CMP: begin
        h_we = 1'b1;
        if (ins_move) begin
          h_wdata = h_rdata;
          t_nxt   = t_r >> 1;
        end else begin
          if (build_r) col_nxt = col_r + FW'(1);
          else         i_nxt   = i_r + FW'(1);
        end
      end
      S_POP_CHK: h_raddr = HAW'(1);
      S_POP_TOP: begin
        last_nxt = hr_val;
        pc_nxt   = h_rdata[CW-1:0];
        h_raddr  = HAW'(size_r);
      end
      S_POP_LAST: begin
        key_nxt  = h_rdata;
        size_nxt = size_r - FW'(1);
        t_nxt    = FW'(1);
      end
      S_SD_NEXT: begin
        h_raddr = HAW'(two_t);
        if (!has_child) h_we = 1'b1;
      end
      S_SD_L: begin
        left_nxt = h_rdata;
        h_raddr  = HAW'(two_t + (FW+1)'(1));
        if (!has_right) begin
          h_we = 1'b1;
          if (left_move) begin
            h_wdata = h_rdata;
            t_nxt   = FW'(two_t);
          end
        end
      end
      S_SD_R: begin
        h_we = 1'b1;
        if (ch_move) begin
          h_wdata = ch_word;
          t_nxt   = ch_idx;
        end
      end
      S_POP_FILL: begin
        f_we    = 1'b1;
        f_waddr = pc_r;
        f_wdata = pop_fill_m1;
        cur_nxt = pc_r;
        s_raddr = SAW'(pc_r) * SAW'(MAX_N) + SAW'(pop_fill_m1 - FW'(1));
        if (pop_fill_m1 == '0) i_nxt = i_r + FW'(1);
      end
      S_DONE: begin
        out_strobe = 1'b1;
        items_nxt  = '0;
      end
      S_CLR: begin
        f_we    = 1'b1;
        f_waddr = CW'(clr_r);
        f_wdata = '0;
        clr_nxt = (clr_r == FW'(MAX_N - 1)) ? '0 : clr_r + FW'(1);
      end
      default: ;
    endcase
  end

  assign busy            = (st_r != S_IDLE);
  assign out_nth_largest = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= S_CLR;
      cfg_r   <= CFG_W'(1);
      items_r <= '0;
      build_r <= 1'b0;
      clr_r   <= '0;
    end else begin
      st_r    <= st_nxt;
      items_r <= items_nxt;
      build_r <= build_nxt;
      clr_r   <= clr_nxt;
      if (cfg_we) cfg_r <= cfg_n_used;
    end
  end

  always_ff @(posedge clk) begin
    dsh_r   <= dsh_nxt;
    dcnt_r  <= dcnt_nxt;
    rem_r   <= rem_nxt;
    col_r   <= col_nxt;
    i_r     <= i_nxt;
    size_r  <= size_nxt;
    t_r     <= t_nxt;
    cur_r   <= cur_nxt;
    pc_r    <= pc_nxt;
    key_r   <= key_nxt;
    left_r  <= left_nxt;
    last_r  <= last_nxt;
    value_r <= value_nxt;
  end

  // column entries, column c at c*MAX_N
  nlcm_ram #(.W(VAL_W), .DEPTH(SD)) u_store (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (value_r),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // entries held per column
  nlcm_ram #(.W(FW), .DEPTH(MAX_N)) u_fill (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  // heap slots 1..MAX_N, each {top value, column}
  nlcm_ram #(.W(KW), .DEPTH(HD)) u_heap (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

endmodule
